// ===== src/rsd_pkg.sv =====
// ---------------------------------------------------------------------------
// rsd_pkg: shared types and constants for the RLE sprite row decoder
// Field widths, register indexes, result kinds and the config bundle.
// ---------------------------------------------------------------------------
package rsd_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned LIT_W   = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

    // result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CODE_W-1:0]  t_code;

    // configuration seen by the decoder
    typedef struct packed {
        t_coord origin_x;
        t_coord origin_y;
        t_coord height;
        logic   restart;     // height written this cycle
        t_coord new_height;  // value being written with restart
    } t_cfg;

endpackage

// ===== src/rsd_ifs.sv =====
// ---------------------------------------------------------------------------
// rsd_ifs: handshake channels of the RLE sprite row decoder
// Code byte stream, result stream and configuration write channel.
// ---------------------------------------------------------------------------
interface rsd_code_if;
    logic                 valid;
    logic                 ready;
    logic [rsd_pkg::CODE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface rsd_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic signed [rsd_pkg::COORD_W-1:0] pixel_x;
    logic signed [rsd_pkg::COORD_W-1:0] pixel_y;
    logic [rsd_pkg::CODE_W-1:0]  color_index;

    modport source (output valid, output result_kind, output pixel_x, output pixel_y,
                    output color_index, input ready);
    modport sink   (input valid, input result_kind, input pixel_x, input pixel_y,
                    input color_index, output ready);
endinterface

interface rsd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rsd_pkg::CFG_IDX_W-1:0]  index;
    logic [rsd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/rle_sprite_row_decoder.sv =====
// ---------------------------------------------------------------------------
// rle_sprite_row_decoder: transparent run-length sprite decoder
// Turns a sprite byte stream into opaque pixel items and a finish item.
// ---------------------------------------------------------------------------
// Takes one stream byte per cycle while the result sink keeps up and gives
// at most one result item per byte; a byte passes through the input register
// and then the result register, and decode state updates in the single pass
// between the two. A stalled result holds the input register and then the
// byte channel. Writing the height register restarts decoding at the
// configured origin.
module rle_sprite_row_decoder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rsd_cfg_if.sink  i_cfg,
    rsd_code_if.sink i_code,
    rsd_pix_if.source o_pix
);

    rsd_pkg::t_cfg w_cfg;

    rsd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    rsd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_code  (i_code),
        .o_pix   (o_pix)
    );

endmodule

// ===== src/rsd_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// rsd_cfg_regs: configuration registers
// Holds origin and height; flags a restart when the height is written.
// ---------------------------------------------------------------------------
module rsd_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rsd_cfg_if.sink         i_cfg,
    output rsd_pkg::t_cfg   o_cfg
);

    rsd_pkg::t_coord r_origin_x;
    rsd_pkg::t_coord r_origin_y;
    rsd_pkg::t_coord r_height;
    logic            w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_height   <= '0;
        end else if (w_wr) begin
            unique case (i_cfg.index)
                rsd_pkg::REG_ORIGIN_X: r_origin_x <= i_cfg.data;
                rsd_pkg::REG_ORIGIN_Y: r_origin_y <= i_cfg.data;
                rsd_pkg::REG_HEIGHT:   r_height   <= i_cfg.data;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    always_comb begin
        o_cfg.origin_x   = r_origin_x;
        o_cfg.origin_y   = r_origin_y;
        o_cfg.height     = r_height;
        o_cfg.restart    = w_wr && (i_cfg.index == rsd_pkg::REG_HEIGHT);
        o_cfg.new_height = i_cfg.data;
    end

endmodule

// ===== src/rsd_decode.sv =====
// ---------------------------------------------------------------------------
// rsd_decode: byte decoder
// Input register, decode state and result register in one pass per item.
// ---------------------------------------------------------------------------
module rsd_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsd_pkg::t_cfg  i_cfg,
    rsd_code_if.sink       i_code,
    rsd_pix_if.source      o_pix
);

    // input stage
    logic                 r_in_valid;
    rsd_pkg::t_code       r_in_byte;
    // decode state
    rsd_pkg::t_coord      r_cursor_x, n_cursor_x;
    rsd_pkg::t_coord      r_rows_done, n_rows_done;
    logic [rsd_pkg::LIT_W-1:0] r_lit_left, n_lit_left;
    logic                 r_finished, n_finished;
    // result stage
    logic                 r_out_valid;
    logic                 r_out_kind, n_out_kind;
    rsd_pkg::t_coord      r_out_x, n_out_x;
    rsd_pkg::t_coord      r_out_y, n_out_y;
    rsd_pkg::t_code       r_out_color, n_out_color;

    logic                 w_adv;      // result stage can take a new result
    logic                 w_exec;     // registered byte is decoded this cycle
    logic                 w_emit;
    rsd_pkg::t_coord      w_rows_inc;
    logic [8:0]           w_skip;

    assign w_adv        = !r_out_valid || o_pix.ready;
    assign w_exec       = r_in_valid && w_adv;
    assign i_code.ready = !r_in_valid || w_adv;

    assign w_rows_inc = r_rows_done + 16'd1;
    assign w_skip     = 9'd256 - {1'b0, r_in_byte};

    always_comb begin
        n_cursor_x  = r_cursor_x;
        n_rows_done = r_rows_done;
        n_lit_left  = r_lit_left;
        n_finished  = r_finished;
        w_emit      = 1'b0;
        n_out_kind  = rsd_pkg::KIND_PIXEL;
        n_out_x     = r_cursor_x;
        n_out_y     = i_cfg.origin_y + r_rows_done;
        n_out_color = r_in_byte;
        if (w_exec && !r_finished) begin
            if (r_lit_left != '0) begin
                w_emit     = 1'b1;
                n_cursor_x = r_cursor_x + 16'd1;
                n_lit_left = r_lit_left - 7'd1;
            end else if (r_in_byte == '0) begin
                // end of row
                n_rows_done = w_rows_inc;
                n_cursor_x  = i_cfg.origin_x;
                if (w_rows_inc == i_cfg.height) begin
                    n_finished  = 1'b1;
                    w_emit      = 1'b1;
                    n_out_kind  = rsd_pkg::KIND_FINISH;
                    n_out_x     = '0;
                    n_out_y     = '0;
                    n_out_color = '0;
                end
            end else if (!r_in_byte[7]) begin
                n_lit_left = r_in_byte[rsd_pkg::LIT_W-1:0];
            end else begin
                // transparent skip by the magnitude
                n_cursor_x = r_cursor_x + {7'd0, w_skip};
            end
        end
        if (i_cfg.restart) begin
            n_cursor_x  = i_cfg.origin_x;
            n_rows_done = '0;
            n_lit_left  = '0;
            n_finished  = (i_cfg.new_height == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cursor_x  <= '0;
            r_rows_done <= '0;
            r_lit_left  <= '0;
            r_finished  <= 1'b1;
        end else begin
            if (i_code.ready) begin
                r_in_valid <= i_code.valid;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            r_cursor_x  <= n_cursor_x;
            r_rows_done <= n_rows_done;
            r_lit_left  <= n_lit_left;
            r_finished  <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_code.ready && i_code.valid) begin
            r_in_byte <= i_code.code_byte;
        end
        if (w_emit) begin
            r_out_kind  <= n_out_kind;
            r_out_x     <= n_out_x;
            r_out_y     <= n_out_y;
            r_out_color <= n_out_color;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.result_kind = r_out_kind;
    assign o_pix.pixel_x     = r_out_x;
    assign o_pix.pixel_y     = r_out_y;
    assign o_pix.color_index = r_out_color;

endmodule

// ===== test/rsd_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// rsd_tb_pkg: testbench constants for the RLE sprite row decoder
// The end-of-row code that both the checker and the stimulus use, and the
// spare register index that the stimulus writes.
// ---------------------------------------------------------------------------
package rsd_tb_pkg;

    import rsd_pkg::*;

    // control byte that ends a row
    localparam t_code CODE_END_ROW = 8'h00;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

endpackage

// ===== test/rle_sprite_row_decoder_checker.sv =====
// ---------------------------------------------------------------------------
// rle_sprite_row_decoder_checker: result predictor and scoreboard
// Tracks register writes and accepted stream bytes, decodes them into the
// pixel and finish items the block must give, and compares every accepted
// result with the oldest one still waiting.
// ---------------------------------------------------------------------------
module rle_sprite_row_decoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rsd_cfg_if   i_cfg,
    rsd_code_if  i_code,
    rsd_pix_if   i_pix,
    output int   o_errors,
    output int   o_pending
);

    import rsd_pkg::*;
    import rsd_tb_pkg::*;

    typedef struct packed {
        logic   kind;
        t_coord x;
        t_coord y;
        t_code  color;
    } t_pixel_item;

    t_coord           org_x;
    t_coord           org_y;
    t_coord           sprite_rows;
    t_coord           cur_x;
    t_coord           rows_done;
    logic [LIT_W-1:0] lits_left;
    logic             sprite_done;
    t_code            stream_byte;
    t_pixel_item      got_item;
    t_pixel_item      want_item;
    t_pixel_item      pending_pixels[$];
    int               err_cnt = 0;

    assign o_errors = err_cnt;

    task automatic restart_sprite();
        cur_x       = org_x;
        rows_done   = '0;
        lits_left   = '0;
        sprite_done = (sprite_rows == '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            org_x       = '0;
            org_y       = '0;
            sprite_rows = '0;
            restart_sprite();
            pending_pixels.delete();
            o_pending <= 0;
        end else begin
            // check first: a byte taken at this edge cannot own the result here
            if (i_pix.valid && i_pix.ready) begin
                got_item = '{kind: i_pix.result_kind, x: i_pix.pixel_x,
                             y: i_pix.pixel_y, color: i_pix.color_index};
                if (pending_pixels.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected item kind=%0d x=%h y=%h color=%h",
                             $time, got_item.kind, got_item.x, got_item.y,
                             got_item.color);
                end else begin
                    want_item = pending_pixels.pop_front();
                    if (got_item.kind !== want_item.kind || got_item.x !== want_item.x ||
                        got_item.y !== want_item.y ||
                        got_item.color !== want_item.color) begin
                        err_cnt++;
                        $display("%0t: expected %0d %h %h %h, actual %0d %h %h %h",
                                 $time, want_item.kind, want_item.x, want_item.y,
                                 want_item.color, got_item.kind, got_item.x,
                                 got_item.y, got_item.color);
                    end
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ORIGIN_X: org_x = i_cfg.data;
                    REG_ORIGIN_Y: org_y = i_cfg.data;
                    REG_HEIGHT: begin
                        sprite_rows = i_cfg.data;
                        restart_sprite();
                    end
                    default: ;
                endcase
            end

            // bytes after the last row are dropped
            if (i_code.valid && i_code.ready && !sprite_done) begin
                stream_byte = i_code.code_byte;
                if (lits_left != '0) begin
                    pending_pixels.push_back('{kind: KIND_PIXEL, x: cur_x,
                                               y: t_coord'(org_y + rows_done),
                                               color: stream_byte});
                    cur_x     = cur_x + 1'b1;
                    lits_left = lits_left - 1'b1;
                end else if (stream_byte == CODE_END_ROW) begin
                    rows_done = rows_done + 1'b1;
                    cur_x     = org_x;
                    if (rows_done == sprite_rows) begin
                        sprite_done = 1'b1;
                        pending_pixels.push_back('{kind: KIND_FINISH, x: '0, y: '0,
                                                   color: '0});
                    end
                end else if (!stream_byte[CODE_W-1]) begin
                    lits_left = stream_byte[LIT_W-1:0];
                end else begin
                    // negative count: advance by its magnitude
                    cur_x = cur_x + t_coord'(9'h100 - {1'b0, stream_byte});
                end
            end

            o_pending <= pending_pixels.size();
        end
    end

endmodule

// ===== test/rle_sprite_row_decoder_tb.sv =====
// ---------------------------------------------------------------------------
// rle_sprite_row_decoder_tb: testbench top for the RLE sprite row decoder
// Drives directed and random sprite streams under bursty input and stalled
// output, rewrites origin and height between sprites and the origin within
// a sprite, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module rle_sprite_row_decoder_tb;

    import rsd_pkg::*;
    import rsd_tb_pkg::*;

    localparam int LIVE_TARGET   = 1100;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;

    typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_CHOPPY} t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;
    int   err_count;
    int   pending;

    rsd_cfg_if  cfg_ch ();
    rsd_code_if code_ch ();
    rsd_pix_if  pix_ch ();

    rle_sprite_row_decoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_code  (code_ch),
        .o_pix   (pix_ch)
    );

    rle_sprite_row_decoder_checker chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg     (cfg_ch),
        .i_code    (code_ch),
        .i_pix     (pix_ch),
        .o_errors  (err_count),
        .o_pending (pending)
    );

    int       live_bytes = 0;
    int       burst_left = 0;
    bit       steady     = 1'b0;
    int       hold_asks  = 0;
    int       hold_seen  = 0;
    int       hold_left  = 0;
    int       mode_left  = 0;
    t_rx_mode rx_mode    = RX_STEADY;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("rle_sprite_row_decoder_tb NOT OK");
        $finish;
    end

    // result sink: own stall pattern, plus long holds on request
    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (rx_mode)
                    RX_STEADY:   pix_ch.ready <= 1'b1;
                    RX_RANDOM:   pix_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: pix_ch.ready <= (mode_left % 5 != 0);
                    default:     pix_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    task automatic push_byte(input t_code b, input bit live);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                code_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        code_ch.valid     <= 1'b1;
        code_ch.code_byte <= b;
        do @(posedge clk); while (!code_ch.ready);
        burst_left--;
        if (live)
            live_bytes++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input t_coord value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the stream until every result is out and the pipe is empty
    task automatic wait_idle();
        code_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return t_coord'($urandom());
        endcase
    endfunction

    task automatic send_row(input int max_run);
        int segs;
        int n;
        segs = $urandom_range(0, 4);
        repeat (segs) begin
            if ($urandom_range(0, 2) == 0) begin
                push_byte(t_code'($urandom_range(128, 255)), 1'b1);
            end else begin
                n = ($urandom_range(0, 39) == 0) ? 127 : $urandom_range(1, max_run);
                push_byte(t_code'(n), 1'b1);
                repeat (n) push_byte(t_code'($urandom_range(0, 255)), 1'b1);
            end
        end
        // occasional garbage that breaks the row structure
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) push_byte(t_code'($urandom()), 1'b1);
        push_byte(CODE_END_ROW, 1'b1);
    endtask

    initial begin
        int     phase;
        int     nrows;
        t_coord rows;

        code_ch.valid     <= 1'b0;
        code_ch.code_byte <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        rst_n             <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // height is zero out of reset: everything is dropped
        push_byte(8'h05, 1'b0);
        push_byte(CODE_END_ROW, 1'b0);
        wait_idle();
        set_reg(REG_SPARE, 16'hFFFF);
        set_reg(REG_ORIGIN_X, 16'h7FFE);
        set_reg(REG_ORIGIN_Y, 16'h7FFF);
        set_reg(REG_HEIGHT, 16'd3);
        // literal run across the x wrap, including a zero color
        push_byte(8'h04, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b1);
        push_byte(8'h7F, 1'b1);
        // largest and smallest skip
        push_byte(8'h80, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h02, 1'b1);
        push_byte(8'h55, 1'b1);
        push_byte(8'hAA, 1'b1);
        push_byte(CODE_END_ROW, 1'b1);
        // origin change mid sprite, no restart
        wait_idle();
        set_reg(REG_ORIGIN_Y, 16'h8000);
        set_reg(REG_ORIGIN_X, 16'h0000);
        push_byte(8'h01, 1'b1);
        push_byte(8'h11, 1'b1);
        push_byte(CODE_END_ROW, 1'b1);
        push_byte(CODE_END_ROW, 1'b1);
        push_byte(8'h03, 1'b0);
        wait_idle();
        set_reg(REG_HEIGHT, 16'd0);
        push_byte(8'h01, 1'b0);
        wait_idle();
        set_reg(REG_ORIGIN_Y, 16'hFFFF);
        set_reg(REG_HEIGHT, 16'd1);
        push_byte(CODE_END_ROW, 1'b1);
        wait_idle();

        phase = 0;
        while (live_bytes < LIVE_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 1) == 1)
                set_reg(REG_ORIGIN_X, pick_coord());
            if (phase == 0 || $urandom_range(0, 1) == 1)
                set_reg(REG_ORIGIN_Y, pick_coord());
            if ($urandom_range(0, 15) == 0)
                set_reg(REG_SPARE, t_coord'($urandom()));
            if (phase == 0)
                rows = 16'd3;
            else if (phase == 1)
                rows = 16'hFFFF;
            else if ($urandom_range(0, 9) == 0)
                rows = 16'd0;
            else
                rows = t_coord'($urandom_range(1, 5));
            set_reg(REG_HEIGHT, rows);

            nrows = (rows > 16'd6) ? 3 : int'(rows);
            if (phase == 0) begin
                // stall the sink while the stream keeps coming
                hold_asks++;
                push_byte(8'd60, 1'b1);
                repeat (60) push_byte(t_code'($urandom()), 1'b1);
                push_byte(CODE_END_ROW, 1'b1);
                nrows--;
            end
            repeat (nrows) begin
                send_row($urandom_range(2, 12));
                if ($urandom_range(0, 7) == 0) begin
                    wait_idle();
                    if ($urandom_range(0, 1) == 1)
                        set_reg(REG_ORIGIN_Y, pick_coord());
                    else
                        set_reg(REG_ORIGIN_X, pick_coord());
                end
            end
            repeat ($urandom_range(0, 3)) push_byte(t_code'($urandom()), 1'b0);
            wait_idle();
            phase++;
        end

        steady = 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("rle_sprite_row_decoder_tb OK");
        else
            $display("rle_sprite_row_decoder_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rsd_pkg.sv
src/rsd_ifs.sv
src/rsd_cfg_regs.sv
src/rsd_decode.sv
src/rle_sprite_row_decoder.sv
test/rsd_tb_pkg.sv
test/rle_sprite_row_decoder_checker.sv
test/rle_sprite_row_decoder_tb.sv
